### rtl/core/bpmq_pkg.sv
// Shared constants for the bounded priority message queue.
package bpmq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int LEVELS_DEF   = 3;

    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 11;
    localparam int KIND_W   = 32;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 16;
    localparam int PRIO_W   = 2;

    localparam logic [STATUS_W-1:0] ST_ENQ     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ENQ_DRP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEQ     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPRIO = 3'd4;

endpackage

### rtl/core/bpmq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module bpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bounded_priority_message_queue.sv
// Strict priority message queue with a shared, bounded slot store.
//
// Requests come in on i_valid/o_ready: i_func 0 enqueues a message at level
// i_prio (0 is served first), 1 dequeues the head of the highest non-empty
// level. Every request gives exactly one result on o_valid/i_ready. All levels
// share CAPACITY slots kept as linked lists in a link RAM, with the message
// bodies in a second RAM. When occupancy has reached the configured limit
// (i_cfg_data, 0 or above CAPACITY meaning CAPACITY), an enqueue first drops
// the oldest message of the lowest-priority non-empty level. A request is
// handled in a read step, which reads the link and data RAMs, and an update
// step, which updates the lists and writes back. The next request is taken
// while a finished result still waits in the output register; a request whose
// result cannot be written because the output register is full waits in the
// update cycle. No clearing pass after reset: slots never handed out are
// tracked by a fill count, so the block accepts requests right out of reset.
module bounded_priority_message_queue #(
    parameter int CAPACITY = bpmq_pkg::CAPACITY_DEF,
    parameter int LEVELS   = bpmq_pkg::LEVELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_func,
    input  logic [bpmq_pkg::PRIO_W-1:0]      i_prio,
    input  logic [bpmq_pkg::KIND_W-1:0]      i_msg_kind,
    input  logic [bpmq_pkg::WORD_W-1:0]      i_payload_word,
    input  logic [bpmq_pkg::LEN_W-1:0]       i_payload_len,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bpmq_pkg::STATUS_W-1:0]    o_status,
    output logic [bpmq_pkg::KIND_W-1:0]      o_out_kind,
    output logic [bpmq_pkg::PRIO_W-1:0]      o_out_prio,
    output logic [bpmq_pkg::WORD_W-1:0]      o_out_payload,
    output logic [bpmq_pkg::LEN_W-1:0]       o_out_len,
    output logic [bpmq_pkg::LIMIT_W-1:0]     o_occupancy,
    output logic [31:0]                      o_drop_total,
    // configuration: occupancy limit
    input  logic                             i_cfg_we,
    input  logic [bpmq_pkg::LIMIT_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LV_W   = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int CMP_W  = (CNT_W > bpmq_pkg::LIMIT_W) ? CNT_W : bpmq_pkg::LIMIT_W;
    localparam int DATA_W = bpmq_pkg::KIND_W + bpmq_pkg::WORD_W + bpmq_pkg::LEN_W
                            + bpmq_pkg::PRIO_W;

    typedef enum logic {S_IDLE, S_EXEC} t_state;
    typedef enum logic [2:0] {OP_BAD, OP_EMPTY, OP_DEQ, OP_ENQ, OP_DROP} t_op;

    t_state r_state;
    t_op    r_op, n_op_acc;

    logic [IDX_W-1:0] r_head [LEVELS];
    logic [IDX_W-1:0] r_tail [LEVELS];
    logic [LEVELS-1:0] r_nonempty;
    logic [IDX_W-1:0] r_free_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_fill;
    logic [31:0]      r_drops;
    logic [bpmq_pkg::LIMIT_W-1:0] r_limit;

    logic [IDX_W-1:0] n_head [LEVELS];
    logic [IDX_W-1:0] n_tail [LEVELS];
    logic [LEVELS-1:0] n_nonempty;
    logic [IDX_W-1:0] n_free_head;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_fill;
    logic [31:0]      n_drops;

    // latched request
    logic [LV_W-1:0]  r_lv;
    logic [IDX_W-1:0] r_slot;
    logic [bpmq_pkg::PRIO_W-1:0] r_prio;
    logic [bpmq_pkg::KIND_W-1:0] r_kind;
    logic [bpmq_pkg::WORD_W-1:0] r_word;
    logic [bpmq_pkg::LEN_W-1:0]  r_len;

    // output register
    logic                          r_ovalid;
    logic [bpmq_pkg::STATUS_W-1:0] r_status;
    logic [bpmq_pkg::KIND_W-1:0]   r_okind;
    logic [bpmq_pkg::PRIO_W-1:0]   r_oprio;
    logic [bpmq_pkg::WORD_W-1:0]   r_oword;
    logic [bpmq_pkg::LEN_W-1:0]    r_olen;

    logic accept, out_free, exec_go;
    logic [LV_W-1:0] lo_lv, hi_lv, sel_lv;
    logic            any_ne;
    logic [CMP_W-1:0] limit;
    logic             full;
    logic [IDX_W-1:0] link_raddr;
    logic [IDX_W-1:0] link_rdata;
    logic [DATA_W-1:0] data_rdata;
    logic             link_we;
    logic [IDX_W-1:0] link_waddr, link_wdata;
    logic             data_we;
    logic [IDX_W-1:0] nxt_free;
    logic [LV_W-1:0]  p_lv;
    logic [bpmq_pkg::STATUS_W-1:0] n_status;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign exec_go  = (r_state == S_EXEC) && out_free;

    // level search: first non-empty from the top, last non-empty from the bottom
    always_comb begin
        lo_lv  = '0;
        hi_lv  = '0;
        any_ne = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_nonempty[l]) begin
                lo_lv = LV_W'(l);
            end
        end
        for (int l = 0; l < LEVELS; l++) begin
            if (r_nonempty[l]) begin
                hi_lv  = LV_W'(l);
                any_ne = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_limit == '0 || CMP_W'(r_limit) > CMP_W'(CAPACITY)) begin
            limit = CMP_W'(CAPACITY);
        end else begin
            limit = CMP_W'(r_limit);
        end
        full = (CMP_W'(r_count) >= limit);
    end

    // classify the incoming request and pick the slot to read
    always_comb begin
        if (i_func) begin
            n_op_acc = any_ne ? OP_DEQ : OP_EMPTY;
        end else if (int'(i_prio) >= LEVELS) begin
            n_op_acc = OP_BAD;
        end else if (full && any_ne) begin
            n_op_acc = OP_DROP;
        end else begin
            n_op_acc = OP_ENQ;
        end
        sel_lv = (n_op_acc == OP_DROP) ? hi_lv : lo_lv;
        if (n_op_acc == OP_DEQ || n_op_acc == OP_DROP) begin
            link_raddr = r_head[sel_lv];
        end else begin
            link_raddr = r_free_head;
        end
    end

    bpmq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (accept),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    bpmq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata ({r_kind, r_word, r_len, r_prio}),
        .i_re    (accept),
        .i_raddr (r_head[lo_lv]),
        .o_rdata (data_rdata)
    );

    // slots at or above the fill mark were never handed out: their link is
    // still the reset chain, slot i pointing at i+1
    always_comb begin
        if (CNT_W'(r_slot) >= r_fill) begin
            nxt_free = (int'(r_slot) == CAPACITY - 1) ? '0 : r_slot + 1'b1;
        end else begin
            nxt_free = link_rdata;
        end
    end

    // list update in the write-back cycle
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_free_head = r_free_head;
        n_count     = r_count;
        n_fill      = r_fill;
        n_drops     = r_drops;
        link_we     = 1'b0;
        link_waddr  = r_slot;
        link_wdata  = r_free_head;
        data_we     = 1'b0;
        p_lv        = LV_W'(r_prio);
        n_status    = bpmq_pkg::ST_BADPRIO;

        case (r_op)
            OP_DEQ: begin
                if (r_slot == r_tail[r_lv]) begin
                    n_nonempty[r_lv] = 1'b0;
                end else begin
                    n_head[r_lv] = link_rdata;
                end
                link_we     = 1'b1;
                n_free_head = r_slot;
                n_count     = r_count - 1'b1;
                n_status    = bpmq_pkg::ST_DEQ;
            end
            OP_ENQ, OP_DROP: begin
                if (r_op == OP_DROP) begin
                    // popped slot is reused at once; free list unchanged
                    if (r_slot == r_tail[r_lv]) begin
                        n_nonempty[r_lv] = 1'b0;
                    end else begin
                        n_head[r_lv] = link_rdata;
                    end
                    n_drops  = r_drops + 1'b1;
                    n_status = bpmq_pkg::ST_ENQ_DRP;
                end else begin
                    n_free_head = nxt_free;
                    if (CNT_W'(r_slot) == r_fill) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_count  = r_count + 1'b1;
                    n_status = bpmq_pkg::ST_ENQ;
                end
                data_we = 1'b1;
                if (n_nonempty[p_lv]) begin
                    link_we    = 1'b1;
                    link_waddr = r_tail[p_lv];
                    link_wdata = r_slot;
                end else begin
                    n_head[p_lv]     = r_slot;
                    n_nonempty[p_lv] = 1'b1;
                end
                n_tail[p_lv] = r_slot;
            end
            OP_EMPTY: begin
                n_status = bpmq_pkg::ST_EMPTY;
            end
            default: begin
                n_status = bpmq_pkg::ST_BADPRIO;
            end
        endcase

        if (!exec_go) begin
            link_we = 1'b0;
            data_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_BAD;
            r_nonempty  <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_drops     <= '0;
            r_limit     <= bpmq_pkg::LIMIT_W'(1024);
            r_ovalid    <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            // a new result may replace the one leaving in the same cycle
            if (exec_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                        r_op    <= n_op_acc;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_nonempty  <= n_nonempty;
                        r_free_head <= n_free_head;
                        r_count     <= n_count;
                        r_fill      <= n_fill;
                        r_drops     <= n_drops;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lv   <= sel_lv;
            r_slot <= link_raddr;
            r_prio <= i_prio;
            r_kind <= i_msg_kind;
            r_word <= i_payload_word;
            r_len  <= i_payload_len;
        end
        if (exec_go) begin
            r_status <= n_status;
            if (r_op == OP_DEQ) begin
                {r_okind, r_oword, r_olen, r_oprio} <= data_rdata;
            end else begin
                r_okind <= '0;
                r_oword <= '0;
                r_olen  <= '0;
                r_oprio <= '0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_out_kind    = r_okind;
    assign o_out_prio    = r_oprio;
    assign o_out_payload = r_oword;
    assign o_out_len     = r_olen;
    assign o_occupancy   = bpmq_pkg::LIMIT_W'(r_count);
    assign o_drop_total  = r_drops;

endmodule

### sim/tb.sv
// Testbench for the bounded priority message queue: directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP  = bpmq_pkg::CAPACITY_DEF;
    localparam int LVLS = bpmq_pkg::LEVELS_DEF;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_func = 1'b0;
    logic [bpmq_pkg::PRIO_W-1:0]     i_prio = '0;
    logic [bpmq_pkg::KIND_W-1:0]     i_msg_kind = '0;
    logic [bpmq_pkg::WORD_W-1:0]     i_payload_word = '0;
    logic [bpmq_pkg::LEN_W-1:0]      i_payload_len = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [bpmq_pkg::STATUS_W-1:0]   o_status;
    logic [bpmq_pkg::KIND_W-1:0]     o_out_kind;
    logic [bpmq_pkg::PRIO_W-1:0]     o_out_prio;
    logic [bpmq_pkg::WORD_W-1:0]     o_out_payload;
    logic [bpmq_pkg::LEN_W-1:0]      o_out_len;
    logic [bpmq_pkg::LIMIT_W-1:0]    o_occupancy;
    logic [31:0]                     o_drop_total;
    logic                            i_cfg_we = 1'b0;
    logic [bpmq_pkg::LIMIT_W-1:0]    i_cfg_data = '0;

    bounded_priority_message_queue uut (.*);

    localparam logic FN_ENQ = 1'b0;
    localparam logic FN_DEQ = 1'b1;

    typedef struct packed {
        logic [bpmq_pkg::STATUS_W-1:0] status;
        logic [bpmq_pkg::KIND_W-1:0]   kind;
        logic [bpmq_pkg::PRIO_W-1:0]   prio;
        logic [bpmq_pkg::WORD_W-1:0]   payload;
        logic [bpmq_pkg::LEN_W-1:0]    len;
        logic [bpmq_pkg::LIMIT_W-1:0]  occ;
        logic [31:0]                   drops;
    } t_reply;

    typedef struct packed {
        logic [bpmq_pkg::KIND_W-1:0] kind;
        logic [bpmq_pkg::WORD_W-1:0] word;
        logic [bpmq_pkg::LEN_W-1:0]  len;
    } t_msg;

    // Shadow of the queue: one FIFO per level, message order is all that matters
    // since slot reuse is invisible from outside.
    t_msg        level_q[LVLS][$];
    int unsigned shadow_count;
    logic [31:0] shadow_drops;
    logic [bpmq_pkg::LIMIT_W-1:0] shadow_limit;
    t_reply      pending_replies[$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_limit();
        if (shadow_limit == 0 || shadow_limit > CAP) return CAP;
        return int'(shadow_limit);
    endfunction

    // Predict the reply of one request and update the shadow queue.
    function automatic t_reply queue_predict(logic fn, logic [bpmq_pkg::PRIO_W-1:0] pr,
                                             t_msg m);
        t_reply r;
        r = '0;
        if (fn == FN_ENQ) begin
            if (pr >= LVLS) begin
                r.status = bpmq_pkg::ST_BADPRIO;
            end else begin
                r.status = bpmq_pkg::ST_ENQ;
                if (shadow_count >= eff_limit()) begin
                    // drop oldest of the lowest-priority non-empty level
                    for (int lv = LVLS - 1; lv >= 0; lv--) begin
                        if (level_q[lv].size() != 0) begin
                            void'(level_q[lv].pop_front());
                            shadow_count--;
                            shadow_drops++;
                            r.status = bpmq_pkg::ST_ENQ_DRP;
                            break;
                        end
                    end
                end
                level_q[pr].push_back(m);
                shadow_count++;
            end
        end else begin
            r.status = bpmq_pkg::ST_EMPTY;
            for (int lv = 0; lv < LVLS; lv++) begin
                if (level_q[lv].size() != 0) begin
                    t_msg h;
                    h = level_q[lv].pop_front();
                    r.status  = bpmq_pkg::ST_DEQ;
                    r.kind    = h.kind;
                    r.payload = h.word;
                    r.len     = h.len;
                    r.prio    = bpmq_pkg::PRIO_W'(lv);
                    shadow_count--;
                    break;
                end
            end
        end
        r.occ   = bpmq_pkg::LIMIT_W'(shadow_count);
        r.drops = shadow_drops;
        return r;
    endfunction

    // Send one request; valid holds until accepted and drops only for idle cycles.
    task automatic send_request(logic fn, logic [bpmq_pkg::PRIO_W-1:0] pr, t_msg m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= fn;
        i_prio         <= pr;
        i_msg_kind     <= m.kind;
        i_payload_word <= m.word;
        i_payload_len  <= m.len;
        pending_replies.push_back(queue_predict(fn, pr, m));
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic t_msg rand_msg();
        t_msg m;
        m.kind = $urandom;
        m.word = $urandom;
        m.len  = bpmq_pkg::LEN_W'($urandom);
        return m;
    endfunction

    task automatic enq(logic [bpmq_pkg::PRIO_W-1:0] pr);
        send_request(FN_ENQ, pr, rand_msg());
    endtask

    task automatic deq();
        send_request(FN_DEQ, bpmq_pkg::PRIO_W'($urandom), rand_msg());
    endtask

    // Wait for all replies, plus margin for the pipeline.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [bpmq_pkg::LIMIT_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        shadow_limit = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic empty_queue();
        while (shadow_count != 0) deq();
    endtask

    // Receiver: random stalls, compares each reply with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply status=%0d", o_status);
            end else begin
                t_reply e, a;
                e = pending_replies.pop_front();
                a = '{o_status, o_out_kind, o_out_prio, o_out_payload, o_out_len,
                      o_occupancy, o_drop_total};
                if (a !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reply mismatch: exp st=%0d k=%h p=%0d w=%h l=%h occ=%0d dr=%0d",
                                 e.status, e.kind, e.prio, e.payload, e.len, e.occ, e.drops);
                        $display("                got st=%0d k=%h p=%0d w=%h l=%h occ=%0d dr=%0d",
                                 a.status, a.kind, a.prio, a.payload, a.len, a.occ, a.drops);
                    end
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Extremes of fields, bad priority, empty dequeue, priority order.
    task automatic test_directed();
        t_msg m;
        deq();
        send_request(FN_ENQ, 2'd3, rand_msg());
        m = '{'1, '1, '1};
        send_request(FN_ENQ, 2'd2, m);
        m = '0;
        send_request(FN_ENQ, 2'd0, m);
        enq(2'd1);
        enq(2'd0);
        repeat (5) deq();
        drain();
    endtask

    // Small limit: drops hit the lowest level first, then higher ones.
    task automatic test_drop_policy();
        set_limit(11'd3);
        enq(2'd0); enq(2'd2); enq(2'd1); enq(2'd2); enq(2'd1); enq(2'd0); enq(2'd0);
        enq(2'd0);
        empty_queue();
        set_limit(11'd1);
        enq(2'd1); enq(2'd2); enq(2'd0);
        empty_queue();
        drain();
    endtask

    // Limit lowered below occupancy: occupancy holds, each enqueue drops one.
    task automatic test_limit_lowered();
        set_limit(11'd0);
        repeat (6) enq(bpmq_pkg::PRIO_W'($urandom_range(2)));
        set_limit(11'd2);
        repeat (3) enq(bpmq_pkg::PRIO_W'($urandom_range(2)));
        empty_queue();
        drain();
    endtask

    // Random traffic with sender idle phases, receiver stall phases and varied limits.
    task automatic test_random(int n, int idle, int stall,
                               logic [bpmq_pkg::LIMIT_W-1:0] lim);
        set_limit(lim);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(99);
            if (r < 8)       send_request(FN_ENQ, 2'd3, rand_msg());
            else if (r < 55) enq(bpmq_pkg::PRIO_W'($urandom_range(2)));
            else             deq();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    // Limit above capacity saturates: a burst well below capacity sees no drop.
    task automatic test_limit_saturates();
        set_limit(11'd2047);
        repeat (40) enq(bpmq_pkg::PRIO_W'($urandom_range(2)));
        empty_queue();
        set_limit(11'd1024);
        drain();
    endtask

    initial begin
        shadow_count = 0;
        shadow_drops = '0;
        shadow_limit = 11'd1024;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drop_policy();
        test_limit_lowered();
        test_random(210, 0, 0, 11'd8);
        test_random(210, 52, 0, 11'd5);
        test_random(210, 0, 52, 11'd1024);
        test_random(210, 28, 28, 11'd3);
        test_limit_saturates();
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
rtl/core/bpmq_pkg.sv
rtl/core/bpmq_ram.sv
rtl/core/bounded_priority_message_queue.sv
sim/tb.sv
